FILE: rtl/core/lpr_pkg.sv
// Shared types and constants for the longest-prefix route lookup block.
// Holds the request and response payload structs and the controller interface.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lpr_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef struct packed {
    logic        func;
    logic [3:0]  entry_index;
    logic        entry_valid;
    logic [31:0] entry_dest;
    logic [31:0] entry_mask;
    logic [31:0] entry_gateway;
    logic [3:0]  entry_port;
    logic [31:0] lookup_addr;
  } lpr_req_t;

  typedef struct packed {
    logic        hit;
    logic [3:0]  match_index;
    logic        exact_match;
    logic [31:0] next_hop;
    logic [3:0]  out_port;
  } lpr_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } lpr_state_t;

  typedef struct packed {
    logic             load;
    logic             rd;
    logic [IDX_W-1:0] rd_idx;
    logic             finish;
  } lpr_cmd_t;

  typedef struct packed {
    logic out_free;
  } lpr_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/lpr_ctrl.sv
// Controller for the route lookup: sequences request load, table scan and
// response hand-off. Depends on lpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpr_ctrl
  import lpr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  input  wire logic     req_func,
  output logic          req_stall,
  input  wire lpr_sts_t sts,
  output lpr_cmd_t      cmd
);

  lpr_state_t       state, state_next;
  logic [IDX_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    req_stall  = 1'b1;
    cmd        = '0;
    cmd.rd_idx = cnt;
    unique case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.load = 1'b1;
          cnt_next = '0;
          state_next = (req_func == FUNC_LOOKUP) ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        cmd.rd = 1'b1;
        if (cnt == IDX_W'(TABLE_ENTRIES - 1)) begin
          state_next = ST_DRAIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/lpr_datapath.sv
// Datapath for the route lookup: route table, best-match tracking,
// configuration register and response register. Depends on lpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpr_datapath
  import lpr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire lpr_req_t req,
  input  wire lpr_cmd_t cmd,
  output lpr_sts_t      sts,
  input  wire logic     cfg_valid,
  input  wire logic     cfg_data,
  output logic          cfg_ready,
  output logic          rsp_valid,
  input  wire logic     rsp_stall,
  output lpr_rsp_t      rsp
);

  logic                     router_active;
  logic [TABLE_ENTRIES-1:0] route_valid;
  logic [31:0]              route_dest    [TABLE_ENTRIES];
  logic [31:0]              route_mask    [TABLE_ENTRIES];
  logic [31:0]              route_gateway [TABLE_ENTRIES];
  logic [3:0]               route_port    [TABLE_ENTRIES];

  // Latched request.
  logic        cur_func;
  logic [31:0] cur_addr;

  // Registered table read.
  logic             rd_vld;
  logic [IDX_W-1:0] rd_idx_q;
  logic             rd_vbit;
  logic [31:0]      rd_dest;
  logic [31:0]      rd_mask;
  logic [31:0]      rd_gw;
  logic [3:0]       rd_port;

  // Best match so far.
  logic             found;
  logic             exact;
  logic [IDX_W-1:0] best_idx;
  logic [31:0]      best_mask;
  logic [31:0]      best_gw;
  logic [3:0]       best_port;

  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic             prefix_hit;
  logic             dest_equal;
  logic             take;
  lpr_rsp_t         rsp_next;

  assign cfg_ready    = 1'b1;
  assign sts.out_free = !rsp_valid || !rsp_stall;

  assign wr_en  = cmd.load && (req.func == FUNC_WRITE) &&
                  (32'(req.entry_index) < TABLE_ENTRIES);
  assign wr_idx = IDX_W'(req.entry_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      router_active <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      router_active <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      route_valid <= '0;
    end else if (wr_en) begin
      route_valid[wr_idx] <= req.entry_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      route_dest[wr_idx]    <= req.entry_dest;
      route_mask[wr_idx]    <= req.entry_mask;
      route_gateway[wr_idx] <= req.entry_gateway;
      route_port[wr_idx]    <= req.entry_port;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_q <= cmd.rd_idx;
    rd_vbit  <= route_valid[cmd.rd_idx];
    rd_dest  <= route_dest[cmd.rd_idx];
    rd_mask  <= route_mask[cmd.rd_idx];
    rd_gw    <= route_gateway[cmd.rd_idx];
    rd_port  <= route_port[cmd.rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_func <= req.func;
      cur_addr <= req.lookup_addr;
    end
  end

  // An exact hit ends the search, so later entries are ignored once it is set.
  assign prefix_hit = rd_vld && rd_vbit && !exact &&
                      ((cur_addr & rd_mask) == (rd_dest & rd_mask));
  assign dest_equal = (rd_dest == cur_addr);
  assign take       = prefix_hit && (dest_equal || !found || (rd_mask >= best_mask));

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
      exact <= 1'b0;
    end else if (cmd.load) begin
      found <= 1'b0;
      exact <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
      exact <= dest_equal;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_idx  <= rd_idx_q;
      best_mask <= rd_mask;
      best_gw   <= rd_gw;
      best_port <= rd_port;
    end
  end

  always_comb begin
    rsp_next = '0;
    if ((cur_func == FUNC_LOOKUP) && router_active && found) begin
      rsp_next.hit         = 1'b1;
      rsp_next.match_index = 4'(best_idx);
      rsp_next.exact_match = exact;
      rsp_next.next_hop    = (best_gw == 32'd0) ? cur_addr : best_gw;
      rsp_next.out_port    = best_port;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.finish) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/longest_prefix_route_lookup.sv
// Top level of the longest-prefix route lookup block.
// Instantiates lpr_ctrl and lpr_datapath; depends on lpr_pkg.
//
// Usage:
// A request arrives on req with req_valid and is taken at a rising edge where
// req_stall is low. A request either writes one slot of the 16-entry route
// table (func = 0) or looks up an address (func = 1). Every request yields
// exactly one response on rsp, offered with rsp_valid and taken at an edge
// where rsp_stall is low. Writes answer with an all-zero response.
// A lookup scans one entry per cycle through a registered read and passes
// a drain state before it loads the response register; a write goes from
// acceptance straight to the finish state. req_stall is high while a request
// is in work, and the next one is taken in the cycle after the response loads.
// The response sits in its own register, so the block accepts the next
// request while the previous response still waits. When the receiver keeps
// rsp_stall high, a finished lookup waits in the controller until the
// response register frees, and the request side then stays stalled.
// The router_active register is written through cfg_valid/cfg_data; it is
// always ready. Reset clears all slot valid bits, router_active, and the
// response valid; the table contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module longest_prefix_route_lookup
  import lpr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_stall,
  input  wire lpr_req_t req,
  output logic          rsp_valid,
  input  wire logic     rsp_stall,
  output lpr_rsp_t      rsp,
  input  wire logic     cfg_valid,
  output logic          cfg_ready,
  input  wire logic     cfg_data
);

  lpr_cmd_t cmd;
  lpr_sts_t sts;

  // The controller sequences load, scan and hand-off; all table and
  // match state lives in the datapath.
  lpr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_func  (req.func),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  lpr_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire
